// ===== hdl/soft_clip_waveshaper_top_macros.svh =====
// Assertion macros shared by the soft clip waveshaper RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SOFT_CLIP_WAVESHAPER_TOP_MACROS_SVH
`define SOFT_CLIP_WAVESHAPER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/scw_pkg.sv =====
// Shared constants and types of the soft clip waveshaper.
// Depends on nothing; used by every module of the block.
`default_nettype none

package scw_pkg;

   localparam int DEFAULT_SAMPLE_WIDTH = 16;
   localparam int DRIVE_WIDTH = 16;
   // Threshold t = 1 - drive in Q0.16, range 1 .. 65536.
   localparam int THRESH_WIDTH = 17;
   localparam int THRESH_FRAC = 16;
   // Divisor t * (2 + t) in units of 2^-32 stays below 2^34.
   localparam int DEN_WIDTH = 34;
   // Linear region numerator is 2u scaled by 2^32.
   localparam int LIN_SHIFT = 33;

   localparam logic [DRIVE_WIDTH-1:0] DRIVE_RESET = '0;
   localparam logic [THRESH_WIDTH-1:0] THRESH_ONE = 17'h10000;
   localparam logic [THRESH_WIDTH:0] DEN_OFFSET = 18'h20000;

   typedef enum logic [1:0] {
      REGION_LINEAR,
      REGION_KNEE,
      REGION_FLAT
   } region_type;

   typedef struct packed {
      region_type region;
      logic neg;
      logic last;
   } ctrl_type;

endpackage

`default_nettype wire

// ===== hdl/scw_prep.sv =====
// Front end of the waveshaper: magnitude, region decision and divider operands.
// Depends on scw_pkg and the assertion macro header.
`default_nettype none
`include "soft_clip_waveshaper_top_macros.svh"

module scw_prep #(
   parameter int SAMPLE_WIDTH = scw_pkg::DEFAULT_SAMPLE_WIDTH,
   localparam int NUM_W = SAMPLE_WIDTH - 1 + scw_pkg::DEN_WIDTH
) (
   input  logic clock,
   input  logic reset,
   input  logic valid_i,
   output logic ready_o,
   input  logic [SAMPLE_WIDTH-1:0] sample_i,
   input  logic last_i,
   input  logic [scw_pkg::DRIVE_WIDTH-1:0] drive_i,
   output logic valid_o,
   input  logic ready_i,
   output scw_pkg::ctrl_type ctrl_o,
   output logic [scw_pkg::DEN_WIDTH-1:0] den_o,
   output logic [NUM_W-1:0] num_o
);

   localparam int FRAC = SAMPLE_WIDTH - 1;
   localparam int SCALE_W = FRAC + 18;
   localparam int GSHIFT = (FRAC < 16) ? FRAC : 16;
   localparam int EW = ((FRAC > 16) ? FRAC : 16) + 1;
   localparam int SQ_SHIFT = 2 * GSHIFT - FRAC;
   localparam int TW = scw_pkg::THRESH_WIDTH;

   // Stage A signals.
   logic neg;
   logic [SAMPLE_WIDTH-1:0] u_mag;
   logic [TW-1:0] thresh;
   logic [SCALE_W-1:0] u_scaled;
   logic [SCALE_W-1:0] t_scaled;
   logic [SCALE_W-1:0] t2_scaled;
   logic [SCALE_W-1:0] err_full;
   scw_pkg::region_type region;
   logic a_en;
   logic a_valid_ff;
   scw_pkg::ctrl_type a_ctrl_ff;
   logic [SAMPLE_WIDTH-1:0] a_u_ff;
   logic [TW-1:0] a_t_ff;
   logic [EW-1:0] a_e0_ff;

   // Stage B signals.
   logic [TW:0] t_sum;
   logic [2*TW:0] den_full;
   logic [2*EW-1:0] err_sq;
   logic [NUM_W-1:0] num_in;
   logic b_en;
   logic b_valid_ff;
   scw_pkg::ctrl_type b_ctrl_ff;
   logic [scw_pkg::DEN_WIDTH-1:0] b_den_ff;
   logic [NUM_W-1:0] b_num_ff;

   always_comb begin
      neg = sample_i[SAMPLE_WIDTH-1];
      u_mag = neg ? (SAMPLE_WIDTH'(0) - sample_i) : sample_i;
      thresh = scw_pkg::THRESH_ONE - TW'(drive_i);
      u_scaled = SCALE_W'(u_mag) << scw_pkg::THRESH_FRAC;
      t_scaled = SCALE_W'(thresh) << FRAC;
      t2_scaled = t_scaled << 1;
      // Distance from the knee end, 2t - u, valid in the knee region.
      err_full = t2_scaled - u_scaled;
      priority if (u_scaled > t2_scaled) begin
         region = scw_pkg::REGION_FLAT;
      end else if (u_scaled < t_scaled) begin
         region = scw_pkg::REGION_LINEAR;
      end else begin
         region = scw_pkg::REGION_KNEE;
      end
   end

   assign b_en = !b_valid_ff || ready_i;
   assign a_en = !a_valid_ff || b_en;
   assign ready_o = a_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_en) begin
         a_valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_ctrl_ff <= '{region: region, neg: neg, last: last_i};
         a_u_ff <= u_mag;
         a_t_ff <= thresh;
         a_e0_ff <= err_full[GSHIFT +: EW];
      end
   end

   always_comb begin
      t_sum = scw_pkg::DEN_OFFSET + (TW + 1)'(a_t_ff);
      den_full = (2 * TW + 1)'(a_t_ff) * (2 * TW + 1)'(t_sum);
      err_sq = (2 * EW)'(a_e0_ff) * (2 * EW)'(a_e0_ff);
      unique case (a_ctrl_ff.region)
         scw_pkg::REGION_LINEAR: begin
            num_in = NUM_W'(a_u_ff) << scw_pkg::LIN_SHIFT;
         end
         scw_pkg::REGION_KNEE: begin
            num_in = NUM_W'(err_sq) << SQ_SHIFT;
         end
         default: begin
            num_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_en) begin
         b_ctrl_ff <= a_ctrl_ff;
         b_den_ff <= den_full[scw_pkg::DEN_WIDTH-1:0];
         b_num_ff <= num_in;
      end
   end

   assign valid_o = b_valid_ff;
   assign ctrl_o = b_ctrl_ff;
   assign den_o = b_den_ff;
   assign num_o = b_num_ff;

   // The quotient must fit the divider's bit count.
   `SCW_ASSERT_NOW(a_num_fits, clock, reset, b_valid_ff,
      b_num_ff[NUM_W-1:FRAC] < b_den_ff, "scw_prep: numerator overflows divider")

endmodule

`default_nettype wire

// ===== hdl/scw_div_step.sv =====
// One restoring division step: develops one quotient bit per register stage.
// Depends on scw_pkg.
`default_nettype none

module scw_div_step #(
   parameter int SAMPLE_WIDTH = scw_pkg::DEFAULT_SAMPLE_WIDTH
) (
   input  logic clock,
   input  logic reset,
   input  logic valid_i,
   output logic ready_o,
   input  scw_pkg::ctrl_type ctrl_i,
   input  logic [scw_pkg::DEN_WIDTH-1:0] den_i,
   input  logic [scw_pkg::DEN_WIDTH-1:0] rem_i,
   input  logic [SAMPLE_WIDTH-2:0] low_i,
   input  logic [SAMPLE_WIDTH-2:0] quo_i,
   output logic valid_o,
   input  logic ready_i,
   output scw_pkg::ctrl_type ctrl_o,
   output logic [scw_pkg::DEN_WIDTH-1:0] den_o,
   output logic [scw_pkg::DEN_WIDTH-1:0] rem_o,
   output logic [SAMPLE_WIDTH-2:0] low_o,
   output logic [SAMPLE_WIDTH-2:0] quo_o
);

   localparam int FRAC = SAMPLE_WIDTH - 1;
   localparam int DW = scw_pkg::DEN_WIDTH;

   logic [DW:0] trial;
   logic [DW:0] den_x;
   logic [DW:0] diff;
   logic take;
   logic en;
   logic valid_ff;
   scw_pkg::ctrl_type ctrl_ff;
   logic [DW-1:0] den_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] rem_in;
   logic [FRAC-1:0] low_ff;
   logic [FRAC-1:0] quo_ff;

   always_comb begin
      trial = {rem_i, low_i[FRAC-1]};
      den_x = {1'b0, den_i};
      diff = trial - den_x;
      take = (trial >= den_x);
      rem_in = take ? diff[DW-1:0] : trial[DW-1:0];
   end

   assign en = !valid_ff || ready_i;
   assign ready_o = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctrl_ff <= ctrl_i;
         den_ff <= den_i;
         rem_ff <= rem_in;
         low_ff <= low_i << 1;
         quo_ff <= {quo_i[FRAC-2:0], take};
      end
   end

   assign valid_o = valid_ff;
   assign ctrl_o = ctrl_ff;
   assign den_o = den_ff;
   assign rem_o = rem_ff;
   assign low_o = low_ff;
   assign quo_o = quo_ff;

endmodule

`default_nettype wire

// ===== hdl/scw_post.sv =====
// Output stage: rounds the quotient, applies the curve, sign and saturation.
// Depends on scw_pkg and the assertion macro header.
`default_nettype none
`include "soft_clip_waveshaper_top_macros.svh"

module scw_post #(
   parameter int SAMPLE_WIDTH = scw_pkg::DEFAULT_SAMPLE_WIDTH
) (
   input  logic clock,
   input  logic reset,
   input  logic valid_i,
   output logic ready_o,
   input  scw_pkg::ctrl_type ctrl_i,
   input  logic [scw_pkg::DEN_WIDTH-1:0] den_i,
   input  logic [scw_pkg::DEN_WIDTH-1:0] rem_i,
   input  logic [SAMPLE_WIDTH-2:0] quo_i,
   output logic valid_o,
   input  logic ready_i,
   output logic [SAMPLE_WIDTH-1:0] sample_o,
   output logic last_o
);

   localparam int FRAC = SAMPLE_WIDTH - 1;
   localparam int DW = scw_pkg::DEN_WIDTH;
   localparam logic [SAMPLE_WIDTH-1:0] ONE_CODE = {1'b1, {FRAC{1'b0}}};
   localparam logic [SAMPLE_WIDTH-1:0] MAX_POS = ONE_CODE - SAMPLE_WIDTH'(1);

   logic [DW:0] rem2;
   logic [DW:0] den_x;
   logic round_lin;
   logic round_knee;
   logic [SAMPLE_WIDTH-1:0] quo_x;
   logic [SAMPLE_WIDTH-1:0] mag;
   logic [SAMPLE_WIDTH-1:0] sample_in;
   logic en;
   logic valid_ff;
   logic [SAMPLE_WIDTH-1:0] sample_ff;
   logic last_ff;

   always_comb begin
      rem2 = {rem_i, 1'b0};
      den_x = {1'b0, den_i};
      // Ties round away from zero in both regions.
      round_lin = (rem2 >= den_x);
      round_knee = (rem2 > den_x);
      quo_x = SAMPLE_WIDTH'(quo_i);
      unique case (ctrl_i.region)
         scw_pkg::REGION_LINEAR: begin
            mag = quo_x + SAMPLE_WIDTH'(round_lin);
         end
         scw_pkg::REGION_KNEE: begin
            mag = ONE_CODE - quo_x - SAMPLE_WIDTH'(round_knee);
         end
         default: begin
            mag = ONE_CODE;
         end
      endcase
      if (ctrl_i.neg) begin
         sample_in = SAMPLE_WIDTH'(0) - mag;
      end else if (mag > MAX_POS) begin
         sample_in = MAX_POS;
      end else begin
         sample_in = mag;
      end
   end

   assign en = !valid_ff || ready_i;
   assign ready_o = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sample_ff <= sample_in;
         last_ff <= ctrl_i.last;
      end
   end

   assign valid_o = valid_ff;
   assign sample_o = sample_ff;
   assign last_o = last_ff;

   `SCW_ASSERT_NEXT(a_pos_stays_pos, clock, reset, en && valid_i && !ctrl_i.neg,
      !sample_ff[SAMPLE_WIDTH-1], "scw_post: positive input gave negative result")
   `SCW_ASSERT_NEXT(a_flat_saturates, clock, reset,
      en && valid_i && !ctrl_i.neg && (ctrl_i.region == scw_pkg::REGION_FLAT),
      sample_ff == MAX_POS, "scw_post: flat region did not saturate")

endmodule

`default_nettype wire

// ===== hdl/soft_clip_waveshaper_top.sv =====
// Top level of the soft clip overdrive waveshaper.
// Depends on scw_pkg, scw_prep, scw_div_step and scw_post.
`default_nettype none

// The block shapes one signed Q1.(SAMPLE_WIDTH-1) sample per item with a
// symmetrical soft clipping curve whose threshold is t = 1 - drive: linear
// below t, a quadratic knee from t to 2t, and full scale above 2t, with the
// sign of the input kept. Results are rounded to the nearest code, with ties
// going away from zero, and saturated, so positive full scale comes out as the
// largest positive code. An item may enter in every clock cycle and one result
// leaves per cycle while rsp_tready is held high. Each item passes through
// two front stages (region decision, then the two multipliers), the divider,
// which produces one quotient bit per pipeline stage, and the rounding output
// register before its result is presented. Each stage holds its own valid
// bit and only stalls when the stage after it is full, so a waiting result
// does not stop new items from entering while the pipeline has room. The
// drive register is written through the csr channel, which is always ready;
// write it only while no items are in flight.
module soft_clip_waveshaper_top #(
   parameter int SAMPLE_WIDTH = scw_pkg::DEFAULT_SAMPLE_WIDTH,
   localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic clock,
   input  logic reset,
   // Input items.
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [TDATA_W-1:0] req_tdata,  // [SAMPLE_WIDTH-1:0] sample_in, rest zero
   input  logic req_tlast,                // block_end
   // Result items.
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,  // [SAMPLE_WIDTH-1:0] sample_out, rest zero
   output logic rsp_tlast,                // last
   // Drive register writes.
   input  logic csr_tvalid,
   output logic csr_tready,
   input  logic [scw_pkg::DRIVE_WIDTH-1:0] csr_tdata  // drive, Q0.16
);

   localparam int FRAC = SAMPLE_WIDTH - 1;
   localparam int DW = scw_pkg::DEN_WIDTH;
   localparam int NUM_W = FRAC + DW;

   logic [scw_pkg::DRIVE_WIDTH-1:0] drive_ff;

   logic prep_valid;
   scw_pkg::ctrl_type prep_ctrl;
   logic [DW-1:0] prep_den;
   logic [NUM_W-1:0] prep_num;

   // Divider chain; index k feeds step k and index k+1 is its output.
   logic div_valid [0:FRAC];
   logic div_ready [0:FRAC];
   scw_pkg::ctrl_type div_ctrl [0:FRAC];
   logic [DW-1:0] div_den [0:FRAC];
   logic [DW-1:0] div_rem [0:FRAC];
   logic [FRAC-1:0] div_low [0:FRAC];
   logic [FRAC-1:0] div_quo [0:FRAC];

   logic [SAMPLE_WIDTH-1:0] sample_out;

   // The drive knob is a plain register; writes never stall.
   assign csr_tready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff <= scw_pkg::DRIVE_RESET;
      end else if (csr_tvalid) begin
         drive_ff <= csr_tdata;
      end
   end

   scw_prep #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_prep (
      .clock(clock),
      .reset(reset),
      .valid_i(req_tvalid),
      .ready_o(req_tready),
      .sample_i(req_tdata[SAMPLE_WIDTH-1:0]),
      .last_i(req_tlast),
      .drive_i(drive_ff),
      .valid_o(prep_valid),
      .ready_i(div_ready[0]),
      .ctrl_o(prep_ctrl),
      .den_o(prep_den),
      .num_o(prep_num)
   );

   // The upper part of the numerator is the starting remainder; the lower
   // FRAC bits are shifted in one per step.
   assign div_valid[0] = prep_valid;
   assign div_ctrl[0] = prep_ctrl;
   assign div_den[0] = prep_den;
   assign div_rem[0] = prep_num[NUM_W-1:FRAC];
   assign div_low[0] = prep_num[FRAC-1:0];
   assign div_quo[0] = '0;

   for (genvar k = 0; k < FRAC; k++) begin : g_div
      scw_div_step #(
         .SAMPLE_WIDTH(SAMPLE_WIDTH)
      ) u_step (
         .clock(clock),
         .reset(reset),
         .valid_i(div_valid[k]),
         .ready_o(div_ready[k]),
         .ctrl_i(div_ctrl[k]),
         .den_i(div_den[k]),
         .rem_i(div_rem[k]),
         .low_i(div_low[k]),
         .quo_i(div_quo[k]),
         .valid_o(div_valid[k+1]),
         .ready_i(div_ready[k+1]),
         .ctrl_o(div_ctrl[k+1]),
         .den_o(div_den[k+1]),
         .rem_o(div_rem[k+1]),
         .low_o(div_low[k+1]),
         .quo_o(div_quo[k+1])
      );
   end

   scw_post #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_post (
      .clock(clock),
      .reset(reset),
      .valid_i(div_valid[FRAC] && (div_low[FRAC] == '0)),
      .ready_o(div_ready[FRAC]),
      .ctrl_i(div_ctrl[FRAC]),
      .den_i(div_den[FRAC]),
      .rem_i(div_rem[FRAC]),
      .quo_i(div_quo[FRAC]),
      .valid_o(rsp_tvalid),
      .ready_i(rsp_tready),
      .sample_o(sample_out),
      .last_o(rsp_tlast)
   );

   assign rsp_tdata = TDATA_W'(sample_out);

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the soft clip overdrive waveshaper top level.
// Depends on scw_pkg and soft_clip_waveshaper_top; drives random and edge-case
// samples across many drive settings and checks every shaped result.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // The block is built at its default sample width. The predictor below is
   // written for Q1.15 samples with a Q0.16 threshold.
   localparam int SW = 16;
   localparam int FRAC = SW - 1;
   localparam longint unsigned ONE_CODE = 64'd1 << FRAC;
   localparam int LATENCY = SW + 2;
   localparam int LONG_HOLD = 300;
   localparam int RANDOM_PER_PHASE = 195;
   localparam longint CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [SW-1:0] sample;
      logic          block_end;
   } sample_item_type;

   typedef struct packed {
      logic [SW-1:0] shaped;
      logic          last;
   } shaped_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [SW-1:0] req_tdata = '0;    // [15:0] sample_in
   logic          req_tlast = 1'b0;  // block_end
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [SW-1:0] rsp_tdata;         // [15:0] sample_out
   logic          rsp_tlast;         // last
   logic          csr_tvalid = 1'b0;
   logic          csr_tready;
   logic [scw_pkg::DRIVE_WIDTH-1:0] csr_tdata = '0;  // drive, Q0.16

   soft_clip_waveshaper_top #(
      .SAMPLE_WIDTH(SW)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_tvalid(csr_tvalid),
      .csr_tready(csr_tready),
      .csr_tdata (csr_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Samples waiting to be offered, and shaped results still owed by the block.
   sample_item_type tx_samples[$];
   shaped_item_type shaped_expect[$];

   // Our own copy of the drive register, updated on every accepted write.
   logic [scw_pkg::DRIVE_WIDTH-1:0] drive_model = scw_pkg::DRIVE_RESET;

   logic req_fired = 1'b0;
   bit   burst_mode = 1'b0;     // no idling on either side while set
   int   hold_requests = 0;     // bumped by the sequencer to ask for a long stall
   int   hold_served = 0;
   int   mismatches = 0;
   int   results_checked = 0;
   int   drive_settings = 0;
   longint cycles = 0;

   // Exact rational evaluation of the soft clipping curve on the integer codes.
   // u is the input magnitude in Q1.15 and t the threshold in Q0.16, so the
   // curve is linear for u < t, a quadratic knee for t <= u <= 2t, and flat
   // beyond. The single rounding is to nearest with ties away from zero.
   function automatic logic [SW-1:0] shaped_sample(input logic [SW-1:0] x,
                                                   input logic [scw_pkg::DRIVE_WIDTH-1:0] drv);
      longint unsigned u, t, den, u_sc, t_sc, num, quo, rem, err, mag;
      logic neg;
      neg = x[SW-1];
      u = neg ? ((64'd1 << SW) - 64'(x)) : 64'(x);
      t = 64'd65536 - 64'(drv);
      den = t * (64'd131072 + t);
      u_sc = u << 16;
      t_sc = t << FRAC;
      if (u_sc > 2 * t_sc) begin
         mag = ONE_CODE;
      end else if (u_sc < t_sc) begin
         num = u << 33;
         quo = num / den;
         rem = num % den;
         mag = quo + ((2 * rem >= den) ? 64'd1 : 64'd0);
      end else begin
         // Distance below the upper breakpoint, both terms in Q0.16.
         err = 2 * t - (u << 1);
         num = (err * err) << 15;
         quo = num / den;
         rem = num % den;
         mag = (2 * rem <= den) ? ONE_CODE - quo : ONE_CODE - quo - 1;
      end
      if (neg) begin
         return SW'((64'd1 << SW) - mag);
      end else begin
         return (mag > ONE_CODE - 1) ? SW'(ONE_CODE - 1) : SW'(mag);
      end
   endfunction

   // Idle length for either side: mostly none, sometimes short, rarely long.
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // Random sample aimed at the current curve: most magnitudes fall below 2t,
   // where the shape is interesting, and some sit right on a breakpoint.
   function automatic logic [SW-1:0] pick_sample(input logic [scw_pkg::DRIVE_WIDTH-1:0] drv);
      int twice_t, u, mode;
      twice_t = 65536 - int'(drv);   // 2t in Q1.15 codes
      mode = $urandom_range(0, 9);
      if (mode < 3) begin
         return SW'($urandom);
      end else if (mode < 7) begin
         u = $urandom_range(0, (twice_t + 2 > 32768) ? 32768 : twice_t + 2);
      end else if (mode == 7) begin
         u = ($urandom_range(0, 1) ? twice_t / 2 : twice_t) + $urandom_range(0, 4) - 2;
      end else if (mode == 8) begin
         case ($urandom_range(0, 3))
            0: u = 0;
            1: u = 1;
            2: u = 32767;
            default: u = 32768;
         endcase
      end else begin
         u = $urandom_range(0, 64);
      end
      if (u < 0) u = 0;
      if (u >= 32768) return 16'h8000;
      return $urandom_range(0, 1) ? SW'(-u) : SW'(u);
   endfunction

   // Input driver: changes at the falling edge, one new item after the
   // previous one was taken and its idle gap has run out.
   int send_gap = 0;
   always @(negedge clock) begin : sample_driver
      sample_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fired) begin
         // Still offered and not yet taken: hold everything steady.
      end else if (send_gap > 0) begin
         send_gap <= send_gap - 1;
         req_tvalid <= 1'b0;
      end else if (tx_samples.size() != 0) begin
         it = tx_samples.pop_front();
         req_tdata <= it.sample;
         req_tlast <= it.block_end;
         req_tvalid <= 1'b1;
         send_gap <= burst_mode ? 0 : pick_idle();
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Output backpressure. A long hold, when asked for, is counted here so that
   // the sender keeps offering items and the pipeline fills up behind it.
   int hold_left = 0;
   int stall_left = 0;
   always @(negedge clock) begin : result_ready
      logic ready_next;
      ready_next = 1'b1;
      if (reset) begin
         ready_next = 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= LONG_HOLD;
         ready_next = 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         ready_next = 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         ready_next = 1'b0;
      end else if (!burst_mode && $urandom_range(0, 3) == 0) begin
         stall_left <= pick_idle();
         ready_next = 1'b0;
      end
      rsp_tready <= ready_next;
   end

   // Monitor: at each rising edge, predict on every accepted sample, track
   // register writes, and compare every accepted result with the oldest
   // expectation.
   always @(posedge clock) begin : result_check
      shaped_item_type want;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end else if (!reset) begin
         req_fired <= req_tvalid && req_tready;
         if (csr_tvalid && csr_tready) begin
            drive_model <= csr_tdata;
         end
         if (req_tvalid && req_tready) begin
            want.shaped = shaped_sample(req_tdata, drive_model);
            want.last = req_tlast;
            shaped_expect.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (shaped_expect.size() == 0) begin
               $error("Result item 0x%h arrived with nothing expected", rsp_tdata);
               mismatches++;
            end else begin
               want = shaped_expect.pop_front();
               results_checked++;
               if (rsp_tdata !== want.shaped) begin
                  $error("sample_out: expected 0x%h, got 0x%h", want.shaped, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_tlast);
                  mismatches++;
               end
            end
         end
      end else begin
         req_fired <= 1'b0;
      end
   end

   task automatic queue_sample(input int value, input logic block_end);
      sample_item_type it;
      it.sample = SW'(value);
      it.block_end = block_end;
      tx_samples.push_back(it);
   endtask

   // Wait until every queued sample was taken and every result came back, then
   // let the pipeline run empty before the next register write.
   task automatic wait_idle();
      @(negedge clock);
      #1;
      while (tx_samples.size() != 0 || req_tvalid || shaped_expect.size() != 0) begin
         @(negedge clock);
         #1;
      end
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic set_drive(input logic [scw_pkg::DRIVE_WIDTH-1:0] value);
      @(negedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata <= value;
      do @(posedge clock); while (!csr_tready);
      @(negedge clock);
      csr_tvalid <= 1'b0;
      drive_settings++;
   endtask

   task automatic random_phase(input logic [scw_pkg::DRIVE_WIDTH-1:0] drv, input bit burst,
                               input bit hold);
      set_drive(drv);
      burst_mode = burst;
      if (hold) hold_requests++;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
         queue_sample(int'(pick_sample(drv)), $urandom_range(0, 7) == 0);
      end
      wait_idle();
      burst_mode = 1'b0;
   endtask

   initial begin : sequencer
      logic [scw_pkg::DRIVE_WIDTH-1:0] drives[10];
      drives = '{16'd0, 16'd65535, 16'd32768, 16'd1, 16'd65534, 16'd61440,
                 16'h0, 16'h0, 16'h0, 16'h0};
      for (int i = 6; i < 10; i++) drives[i] = scw_pkg::DRIVE_WIDTH'($urandom);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Gentlest setting, t = 1: zero, smallest steps, both full scales. The
      // most negative input lands exactly on the knee.
      set_drive(16'd0);
      queue_sample(0, 1'b0);
      queue_sample(1, 1'b1);
      queue_sample(-1, 1'b0);
      queue_sample(32767, 1'b1);
      queue_sample(-32768, 1'b0);
      queue_sample(16384, 1'b1);
      wait_idle();

      // t = 0.25: both sides of each breakpoint, the upper one in both signs, and both full scales.
      set_drive(16'd49152);
      queue_sample(8191, 1'b0);
      queue_sample(8192, 1'b0);
      queue_sample(16384, 1'b1);
      queue_sample(16385, 1'b0);
      queue_sample(-8192, 1'b1);
      queue_sample(-16384, 1'b0);
      queue_sample(-16385, 1'b1);
      queue_sample(32767, 1'b0);
      queue_sample(-32768, 1'b1);
      wait_idle();

      // Hardest setting, t at its smallest: almost everything saturates.
      set_drive(16'd65535);
      queue_sample(0, 1'b1);
      queue_sample(1, 1'b0);
      queue_sample(-1, 1'b1);
      queue_sample(2, 1'b0);
      queue_sample(-2, 1'b1);
      queue_sample(32767, 1'b0);
      queue_sample(-32768, 1'b1);
      wait_idle();

      // Random phases. One runs without any idling, and one starts with a long
      // output hold while samples keep coming, so the input has to stall.
      for (int p = 0; p < 10; p++) begin
         random_phase(drives[p], p == 2, p == 3);
      end

      $display("Checked %0d shaped samples over %0d drive settings,", results_checked,
               drive_settings);
      $display("including breakpoint and full-scale inputs and a long output stall.");
      if (mismatches == 0 && shaped_expect.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
